// ===== src/dtt_pkg.sv =====
`default_nettype none

package dtt_pkg;

  // item function codes
  typedef enum logic [1:0] {
    FuncTick  = 2'd0,
    FuncRead  = 2'd1,
    FuncWrite = 2'd2,
    FuncNone  = 2'd3
  } func_e;

  // register map
  typedef enum logic [3:0] {
    RegPortA  = 4'd0,
    RegPortB  = 4'd1,
    RegDirA   = 4'd2,
    RegDirB   = 4'd3,
    RegTaLo   = 4'd4,
    RegTaHi   = 4'd5,
    RegTbLo   = 4'd6,
    RegTbHi   = 4'd7,
    RegTodTen = 4'd8,
    RegTodSec = 4'd9,
    RegTodMin = 4'd10,
    RegTodHr  = 4'd11,
    RegSdr    = 4'd12,
    RegIcr    = 4'd13,
    RegCra    = 4'd14,
    RegCrb    = 4'd15
  } reg_addr_e;

  // interrupt bit positions
  localparam int unsigned IrqTa     = 0;
  localparam int unsigned IrqTb     = 1;
  localparam int unsigned IrqAlarm  = 2;
  localparam int unsigned IrqSerial = 3;

  // control register bit positions
  localparam int unsigned CtlStart  = 0;
  localparam int unsigned CtlOneShot = 3;
  localparam int unsigned CtlLoad   = 4;
  localparam int unsigned CtlCntMode = 5;
  localparam int unsigned CtlExtra  = 6;

  localparam logic [16:0] TodNtsc = 17'd102273;

  // timer write strobes
  typedef struct packed {
    logic       lo_we;
    logic       hi_we;
    logic       ctrl_we;
    logic [7:0] wdata;
  } tmr_wr_t;

  // two bcd digits to binary, up to 99
  function automatic logic [6:0] from_bcd(input logic [7:0] b);
    logic [6:0] hi;
    hi = {3'd0, b[7:4]};
    return (hi << 3) + (hi << 1) + {3'd0, b[3:0]};
  endfunction

  // binary (below 100) to two bcd digits
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  q;
    logic [6:0]  r;
    prod = {8'd0, v} * 15'd205;
    q    = prod[14:11];
    r    = v - (({3'd0, q} << 3) + ({3'd0, q} << 1));
    return {q, r[3:0]};
  endfunction

  // digit masks per tod register
  function automatic logic [7:0] tod_mask(input logic [1:0] sel);
    logic [7:0] m;
    case (sel)
      2'd0:    m = 8'h0F;
      2'd3:    m = 8'h3F;
      default: m = 8'h7F;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== src/dtt_in_if.sv =====
`default_nettype none

interface dtt_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [3:0] reg_addr;
  logic [7:0] write_data;
  logic       cnt_level;

  modport source (output valid, func, reg_addr, write_data, cnt_level, input ready);
  modport sink   (input valid, func, reg_addr, write_data, cnt_level, output ready);
endinterface

`default_nettype wire

// ===== src/dtt_out_if.sv =====
`default_nettype none

interface dtt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       irq_active;

  modport source (output valid, read_data, irq_active, input ready);
  modport sink   (input valid, read_data, irq_active, output ready);
endinterface

`default_nettype wire

// ===== src/dtt_timer.sv =====
`default_nettype none

module dtt_timer
  import dtt_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        tick_i,
  input  wire tmr_wr_t     wr_i,
  output logic [15:0]      count_o,
  output logic [6:0]       ctrl_o,
  output logic             uflow_o
);

  logic [15:0] count_q, count_d, latch_q, latch_d;
  logic [6:0]  ctrl_q, ctrl_d, cw;

  assign cw      = wr_i.wdata[6:0];
  assign uflow_o = tick_i && (count_q == 16'd1);

  // latch, control and down counter
  always_comb begin
    count_d = count_q;
    latch_d = latch_q;
    ctrl_d  = ctrl_q;
    if (wr_i.lo_we) begin
      latch_d[7:0] = wr_i.wdata;
    end
    if (wr_i.hi_we) begin
      latch_d[15:8] = wr_i.wdata;
    end
    if (wr_i.ctrl_we) begin
      ctrl_d            = cw;
      ctrl_d[CtlLoad]   = 1'b0;
      if (cw[CtlLoad] || (cw[CtlStart] && !ctrl_q[CtlStart])) begin
        count_d = latch_q;
      end
    end else if (tick_i) begin
      if (count_q == 16'd1) begin
        if (ctrl_q[CtlOneShot]) begin
          count_d          = 16'd0;
          ctrl_d[CtlStart] = 1'b0;
        end else begin
          count_d = latch_q;
        end
      end else begin
        count_d = count_q - 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      latch_q <= '0;
      ctrl_q  <= '0;
    end else begin
      count_q <= count_d;
      latch_q <= latch_d;
      ctrl_q  <= ctrl_d;
    end
  end

  assign count_o = count_q;
  assign ctrl_o  = ctrl_q;

endmodule

`default_nettype wire

// ===== src/dtt_tod.sv =====
`default_nettype none

module dtt_tod
  import dtt_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        tick_i,
  input  wire logic [16:0] thr_i,
  input  wire logic        wr_i,
  input  wire logic        rd_i,
  input  wire logic [1:0]  sel_i,
  input  wire logic [7:0]  wdata_i,
  input  wire logic        amode_i,
  input  wire logic        fired_clr_i,
  output logic [7:0]       rdata_o,
  output logic             alarm_o
);

  logic [16:0] presc_q, presc_d, thr;
  logic [17:0] psum;
  logic [6:0]  time_q [4];
  logic [6:0]  time_d [4];
  logic [6:0]  alarm_q [4];
  logic [6:0]  alarm_d [4];
  logic [6:0]  snap_q [4];
  logic [6:0]  snap_d [4];
  logic        held_q, held_d, fired_q, fired_d;
  logic [6:0]  wval;
  logic [7:0]  inc0, inc1, inc2, inc3;
  logic        match;

  assign thr  = (thr_i == '0) ? 17'd1 : thr_i;
  assign psum = {1'b0, presc_q} + 18'd1;
  assign wval = from_bcd(wdata_i & tod_mask(sel_i));
  assign inc0 = {1'b0, time_q[0]} + 8'd1;
  assign inc1 = {1'b0, time_q[1]} + 8'd1;
  assign inc2 = {1'b0, time_q[2]} + 8'd1;
  assign inc3 = {1'b0, time_q[3]} + 8'd1;

  // prescaler, clock chain, register access and alarm
  always_comb begin
    presc_d = presc_q;
    time_d  = time_q;
    alarm_d = alarm_q;
    snap_d  = snap_q;
    held_d  = held_q;
    fired_d = fired_q;
    rdata_o = 8'hFF;
    if (tick_i) begin
      if (psum >= {1'b0, thr}) begin
        presc_d = '0;
        if (inc0 < 8'd10) begin
          time_d[0] = inc0[6:0];
        end else begin
          time_d[0] = '0;
          if (inc1 < 8'd60) begin
            time_d[1] = inc1[6:0];
          end else begin
            time_d[1] = '0;
            if (inc2 < 8'd60) begin
              time_d[2] = inc2[6:0];
            end else begin
              time_d[2] = '0;
              time_d[3] = (inc3 >= 8'd24) ? 7'd0 : inc3[6:0];
            end
          end
        end
      end else begin
        presc_d = psum[16:0];
      end
    end
    if (wr_i) begin
      if (amode_i) begin
        alarm_d[sel_i] = wval;
        fired_d        = 1'b0;
      end else begin
        time_d[sel_i] = wval;
        if (held_q) begin
          snap_d[sel_i] = wval;
        end
      end
    end
    if (rd_i) begin
      if (!held_q) begin
        snap_d  = time_q;
        rdata_o = to_bcd(time_q[sel_i]);
      end else begin
        rdata_o = to_bcd(snap_q[sel_i]);
      end
      held_d = (sel_i != 2'd3);
    end
    if (fired_clr_i) begin
      fired_d = 1'b0;
    end
    match   = (time_d[0] == alarm_q[0]) && (time_d[1] == alarm_q[1]) &&
              (time_d[2] == alarm_q[2]) && (time_d[3] == alarm_q[3]);
    alarm_o = tick_i && match && !fired_q;
    if (alarm_o) begin
      fired_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      presc_q <= '0;
      time_q  <= '{default: '0};
      alarm_q <= '{default: '0};
      snap_q  <= '{default: '0};
      held_q  <= 1'b0;
      fired_q <= 1'b0;
    end else begin
      presc_q <= presc_d;
      time_q  <= time_d;
      alarm_q <= alarm_d;
      snap_q  <= snap_d;
      held_q  <= held_d;
      fired_q <= fired_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/dual_timer_tod_interrupt_unit.sv =====
// Dual 16-bit timer, time-of-day clock and interrupt unit behind 16 byte
// registers. Each transfer on in_i is one clock tick, one register read or
// one register write, and yields exactly one transfer on out_o carrying the
// read byte (0xFF for anything but a read) and the irq level after the item.
// One item is taken every cycle unless a stalled result holds the output
// register; state updates in the accepting cycle and the result is loaded
// into it, refilled in the same cycle it drains. Time-of-day advances one
// tenth every cfg_wdata_i ticks (reset 102273); write it only while idle.
`default_nettype none

module dual_timer_tod_interrupt_unit
  import dtt_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [16:0] cfg_wdata_i,
  dtt_in_if.sink           in_i,
  dtt_out_if.source        out_o
);

  logic        acc, is_tick, is_rd, is_wr;
  reg_addr_e   ra;
  logic [16:0] thr_q;
  logic [7:0]  port_q [4];
  logic [7:0]  port_d [4];
  logic [15:0] snap_a_q, snap_a_d, snap_b_q, snap_b_d;
  logic        snap_a_held_q, snap_a_held_d, snap_b_held_q, snap_b_held_d;
  logic        awm_q, awm_d;
  logic [4:0]  ist_q, ist_d, ien_q, ien_d;
  logic [7:0]  sdr_q, sdr_d, shift_q, shift_d;
  logic [2:0]  scnt_q, scnt_d;
  logic        ovalid_q;
  logic [7:0]  rdata_q, rdata_d, tod_rdata;
  logic        irq_q;
  tmr_wr_t     wr_a, wr_b;
  logic [15:0] count_a, count_b;
  logic [6:0]  ctrl_a, ctrl_b;
  logic        uf_a, uf_b, tick_a, tick_b, tod_wr, tod_rd, tod_alarm, icr_rd;

  assign in_i.ready = !ovalid_q || out_o.ready;
  assign acc        = in_i.valid && in_i.ready;
  assign is_tick    = acc && (func_e'(in_i.func) == FuncTick);
  assign is_rd      = acc && (func_e'(in_i.func) == FuncRead);
  assign is_wr      = acc && (func_e'(in_i.func) == FuncWrite);
  assign ra         = reg_addr_e'(in_i.reg_addr);

  // timer strobes
  always_comb begin
    wr_a.wdata   = in_i.write_data;
    wr_b.wdata   = in_i.write_data;
    wr_a.lo_we   = is_wr && (ra == RegTaLo);
    wr_a.hi_we   = is_wr && (ra == RegTaHi);
    wr_a.ctrl_we = is_wr && (ra == RegCra);
    wr_b.lo_we   = is_wr && (ra == RegTbLo);
    wr_b.hi_we   = is_wr && (ra == RegTbHi);
    wr_b.ctrl_we = is_wr && (ra == RegCrb);
  end

  assign tick_a = is_tick && ctrl_a[CtlStart] && !ctrl_a[CtlCntMode];
  assign tick_b = ctrl_b[CtlStart] &&
                  ((ctrl_b[CtlExtra] && uf_a) ||
                   (is_tick && !ctrl_b[CtlExtra] && !ctrl_b[CtlCntMode]));

  dtt_timer u_timer_a (
    .clk_i, .rst_ni, .tick_i(tick_a), .wr_i(wr_a),
    .count_o(count_a), .ctrl_o(ctrl_a), .uflow_o(uf_a)
  );

  dtt_timer u_timer_b (
    .clk_i, .rst_ni, .tick_i(tick_b), .wr_i(wr_b),
    .count_o(count_b), .ctrl_o(ctrl_b), .uflow_o(uf_b)
  );

  assign tod_wr = is_wr && (in_i.reg_addr[3:2] == 2'b10);
  assign tod_rd = is_rd && (in_i.reg_addr[3:2] == 2'b10);
  assign icr_rd = is_rd && (ra == RegIcr);

  dtt_tod u_tod (
    .clk_i, .rst_ni, .tick_i(is_tick), .thr_i(thr_q),
    .wr_i(tod_wr), .rd_i(tod_rd), .sel_i(in_i.reg_addr[1:0]),
    .wdata_i(in_i.write_data), .amode_i(awm_q),
    .fired_clr_i(icr_rd && ist_q[IrqAlarm]),
    .rdata_o(tod_rdata), .alarm_o(tod_alarm)
  );

  // registers, serial shifter, interrupts and read mux
  always_comb begin
    port_d        = port_q;
    snap_a_d      = snap_a_q;
    snap_b_d      = snap_b_q;
    snap_a_held_d = snap_a_held_q;
    snap_b_held_d = snap_b_held_q;
    awm_d         = awm_q;
    ist_d         = ist_q;
    ien_d         = ien_q;
    sdr_d         = sdr_q;
    shift_d       = shift_q;
    scnt_d        = scnt_q;
    rdata_d       = 8'hFF;
    if (uf_a) begin
      ist_d[IrqTa] = 1'b1;
      if (ctrl_a[CtlExtra]) begin
        shift_d = {shift_q[6:0], in_i.cnt_level};
        if (scnt_q == 3'd7) begin
          sdr_d            = shift_d;
          scnt_d           = '0;
          ist_d[IrqSerial] = 1'b1;
        end else begin
          scnt_d = scnt_q + 3'd1;
        end
      end
    end
    if (uf_b) begin
      ist_d[IrqTb] = 1'b1;
    end
    if (tod_alarm) begin
      ist_d[IrqAlarm] = 1'b1;
    end
    if (is_wr) begin
      unique case (ra)
        RegPortA, RegPortB, RegDirA, RegDirB: port_d[in_i.reg_addr[1:0]] = in_i.write_data;
        RegSdr: sdr_d = in_i.write_data;
        RegIcr: begin
          if (in_i.write_data[7]) begin
            ien_d = ien_q | in_i.write_data[4:0];
          end else begin
            ien_d = ien_q & ~in_i.write_data[4:0];
          end
        end
        RegCra: begin
          if (in_i.write_data[CtlLoad]) begin
            ist_d[IrqTa] = 1'b0;
          end
        end
        RegCrb: begin
          awm_d = in_i.write_data[7];
          if (in_i.write_data[CtlLoad]) begin
            ist_d[IrqTb] = 1'b0;
          end
        end
        default: ;
      endcase
    end
    if (is_rd) begin
      unique case (ra)
        RegPortA, RegPortB, RegDirA, RegDirB: rdata_d = port_q[in_i.reg_addr[1:0]];
        RegTaLo: begin
          snap_a_d      = count_a;
          snap_a_held_d = 1'b1;
          rdata_d       = count_a[7:0];
        end
        RegTaHi: begin
          snap_a_held_d = 1'b0;
          rdata_d       = snap_a_held_q ? snap_a_q[15:8] : count_a[15:8];
        end
        RegTbLo: begin
          snap_b_d      = count_b;
          snap_b_held_d = 1'b1;
          rdata_d       = count_b[7:0];
        end
        RegTbHi: begin
          snap_b_held_d = 1'b0;
          rdata_d       = snap_b_held_q ? snap_b_q[15:8] : count_b[15:8];
        end
        RegTodTen, RegTodSec, RegTodMin, RegTodHr: rdata_d = tod_rdata;
        RegSdr: rdata_d = sdr_q;
        RegIcr: begin
          rdata_d = {|(ist_q & ien_q), 2'b00, ist_q};
          ist_d   = '0;
        end
        RegCra: rdata_d = {1'b0, ctrl_a};
        default: rdata_d = {1'b0, ctrl_b};
      endcase
    end
  end

  // state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q         <= TodNtsc;
      port_q        <= '{8'hFF, 8'hFF, 8'h00, 8'h00};
      snap_a_q      <= '0;
      snap_b_q      <= '0;
      snap_a_held_q <= 1'b0;
      snap_b_held_q <= 1'b0;
      awm_q         <= 1'b0;
      ist_q         <= '0;
      ien_q         <= '0;
      sdr_q         <= '0;
      shift_q       <= '0;
      scnt_q        <= '0;
      ovalid_q      <= 1'b0;
      rdata_q       <= 8'hFF;
      irq_q         <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      port_q        <= port_d;
      snap_a_q      <= snap_a_d;
      snap_b_q      <= snap_b_d;
      snap_a_held_q <= snap_a_held_d;
      snap_b_held_q <= snap_b_held_d;
      awm_q         <= awm_d;
      ist_q         <= ist_d;
      ien_q         <= ien_d;
      sdr_q         <= sdr_d;
      shift_q       <= shift_d;
      scnt_q        <= scnt_d;
      if (acc) begin
        ovalid_q <= 1'b1;
        rdata_q  <= rdata_d;
        irq_q    <= |(ist_d & ien_d);
      end else if (out_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid      = ovalid_q;
  assign out_o.read_data  = rdata_q;
  assign out_o.irq_active = irq_q;

endmodule

`default_nettype wire

// ===== src/dtt_checker.sv =====
`default_nettype none

module dtt_checker
  import dtt_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic [1:0] in_func_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_read_data_i
);

  // every transfer in gives a result next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> out_valid_i)
    else $error("no result after input transfer");

  // non-read items return all ones
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && (in_func_i != FuncRead)) |=> (out_read_data_i == 8'hFF))
    else $error("non-read item returned data");

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_read_data_i)))
    else $error("stalled result changed");

  // input side open whenever output drains
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ready_i || !out_valid_i) |-> in_ready_i)
    else $error("input blocked while output free");

endmodule

bind dual_timer_tod_interrupt_unit dtt_checker u_dtt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .in_func_i       (in_i.func),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_read_data_i (out_o.read_data)
);

`default_nettype wire
